// ----- rtl/greek_digraph_transliterator_defines.svh -----
`ifndef GREEK_DIGRAPH_TRANSLITERATOR_DEFINES_SVH
`define GREEK_DIGRAPH_TRANSLITERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GDT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GDT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/gdt_pkg.sv -----
`timescale 1ns / 1ps

package gdt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int ENTRY_CHARS = 3;
  localparam int CHAR_W      = 8;
  localparam int ENTRY_W     = 24;
  localparam int LEN_W       = 2;
  localparam int RUN_CHARS   = 6;
  localparam int CNT_W       = 3;

  localparam logic [CHAR_W-1:0] CODE_CAP_MU  = 8'd204;
  localparam logic [CHAR_W-1:0] CODE_CAP_NU  = 8'd205;
  localparam logic [CHAR_W-1:0] CODE_SML_MU  = 8'd236;
  localparam logic [CHAR_W-1:0] CODE_SML_NU  = 8'd237;
  localparam logic [CHAR_W-1:0] CODE_SML_TAU = 8'd244;
  localparam logic [CHAR_W-1:0] CODE_CAP_TAU = 8'd212;
  localparam logic [CHAR_W-1:0] CODE_CAP_PI  = 8'd208;
  localparam logic [CHAR_W-1:0] CODE_SML_PI  = 8'd240;
  localparam logic [CHAR_W-1:0] RANGE_BELOW  = 8'd181;
  localparam logic [CHAR_W-1:0] RANGE_ABOVE  = 8'd255;
  localparam logic [CHAR_W-1:0] CHAR_CAP_B   = 8'h42;
  localparam logic [CHAR_W-1:0] CHAR_SML_B   = 8'h62;
  localparam logic [CHAR_W-1:0] CHAR_CAP_D   = 8'h44;
  localparam logic [CHAR_W-1:0] CHAR_SML_D   = 8'h64;

  typedef enum logic {
    OP_TRANSLATE = 1'b0,
    OP_WRITE     = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    HEAD_NONE,
    HEAD_PAIR,
    HEAD_ENTRY
  } head_t;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_RAW,
    TAIL_ENTRY
  } tail_t;

  typedef struct packed {
    head_t             head;
    tail_t             tail;
    logic [CHAR_W-1:0] pair_char;
    logic [CHAR_W-1:0] raw_char;
  } run_ctl_t;

  function automatic logic [LEN_W-1:0] entry_len(input logic [ENTRY_W-1:0] e);
    logic [LEN_W-1:0] n;
    logic             done;
    n    = '0;
    done = 1'b0;
    for (int i = 0; i < ENTRY_CHARS; i++) begin
      if (!done) begin
        if (e[i*CHAR_W +: CHAR_W] == '0) begin
          done = 1'b1;
        end else begin
          n = n + LEN_W'(1);
        end
      end
    end
    return n;
  endfunction

  function automatic logic [ENTRY_W-1:0] entry_trim(input logic [ENTRY_W-1:0] e,
                                                    input logic [LEN_W-1:0] n);
    logic [ENTRY_W-1:0] r;
    r = '0;
    for (int i = 0; i < ENTRY_CHARS; i++) begin
      if (i < int'(n)) begin
        r[i*CHAR_W +: CHAR_W] = e[i*CHAR_W +: CHAR_W];
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/gdt_if.sv -----
`timescale 1ns / 1ps

interface gdt_in_if;
  logic                             valid;
  logic                             ready;
  logic                             operation;
  logic [gdt_pkg::CHAR_W-1:0]       byte_in;
  logic [gdt_pkg::ENTRY_W-1:0]      entry_text;

  modport source (output valid, operation, byte_in, entry_text, input ready);
  modport sink   (input valid, operation, byte_in, entry_text, output ready);
endinterface

interface gdt_out_if;
  logic                             valid;
  logic                             ready;
  logic [gdt_pkg::CHAR_W-1:0]       out_byte;
  logic                             last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

// ----- rtl/gdt_table.sv -----
`timescale 1ns / 1ps

module gdt_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [gdt_pkg::ADDR_W-1:0]    wr_addr,
  input  logic [gdt_pkg::ENTRY_W-1:0]   wr_data,
  input  logic                          rd_en,
  input  logic [gdt_pkg::ADDR_W-1:0]    rd_addr_a,
  input  logic [gdt_pkg::ADDR_W-1:0]    rd_addr_b,
  output logic [gdt_pkg::ENTRY_W-1:0]   rd_data_a,
  output logic [gdt_pkg::ENTRY_W-1:0]   rd_data_b
);
  import gdt_pkg::*;

  logic [ENTRY_W-1:0]     mem_r [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld_r;
  logic [ENTRY_W-1:0]     rd_a_r;
  logic [ENTRY_W-1:0]     rd_b_r;
  logic                   vld_a_r;
  logic                   vld_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem_r[rd_addr_a];
      rd_b_r <= mem_r[rd_addr_b];
    end
  end

  // unwritten entries read as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_a_r <= vld_r[rd_addr_a];
        vld_b_r <= vld_r[rd_addr_b];
      end
    end
  end

  assign rd_data_a = vld_a_r ? rd_a_r : '0;
  assign rd_data_b = vld_b_r ? rd_b_r : '0;

endmodule

// ----- rtl/gdt_emit.sv -----
`timescale 1ns / 1ps
`include "greek_digraph_transliterator_defines.svh"

module gdt_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          run_valid,
  input  gdt_pkg::run_ctl_t             run_ctl,
  input  logic [gdt_pkg::ENTRY_W-1:0]   held_entry,
  input  logic [gdt_pkg::ENTRY_W-1:0]   byte_entry,
  output logic                          take,
  gdt_out_if.source                     out_if
);
  import gdt_pkg::*;

  localparam int LIST_W = RUN_CHARS * CHAR_W;

  logic [RUN_CHARS-1:0][CHAR_W-1:0] buf_r;
  logic [CNT_W-1:0]                 len_r;
  logic [CNT_W-1:0]                 idx_r;
  logic                             busy_r;

  logic [ENTRY_W-1:0] head_v;
  logic [LEN_W-1:0]   head_n;
  logic [ENTRY_W-1:0] tail_v;
  logic [LEN_W-1:0]   tail_n;
  logic [LIST_W-1:0]  list;
  logic [CNT_W-1:0]   cnt;
  logic               last;
  logic               free;
  logic               load;

  always_comb begin
    head_v = '0;
    head_n = '0;
    unique case (run_ctl.head)
      HEAD_NONE: begin
      end
      HEAD_PAIR: begin
        head_v = ENTRY_W'(run_ctl.pair_char);
        head_n = LEN_W'(1);
      end
      HEAD_ENTRY: begin
        head_n = entry_len(held_entry);
        head_v = entry_trim(held_entry, head_n);
      end
      default: begin
      end
    endcase

    tail_v = '0;
    tail_n = '0;
    unique case (run_ctl.tail)
      TAIL_NONE: begin
      end
      TAIL_RAW: begin
        tail_v = ENTRY_W'(run_ctl.raw_char);
        tail_n = LEN_W'(1);
      end
      TAIL_ENTRY: begin
        tail_n = entry_len(byte_entry);
        tail_v = entry_trim(byte_entry, tail_n);
      end
      default: begin
      end
    endcase

    list = (LIST_W'(tail_v) << {head_n, 3'b000}) | LIST_W'(head_v);
    cnt  = CNT_W'(head_n) + CNT_W'(tail_n);
  end

  assign last = (idx_r == len_r - CNT_W'(1));
  assign free = !busy_r || (out_if.ready && last);
  assign load = run_valid && (cnt != '0) && free;
  assign take = run_valid && ((cnt == '0) || free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (busy_r && out_if.ready) begin
      if (last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= list;
      len_r <= cnt;
    end
  end

  assign out_if.valid       = busy_r;
  assign out_if.out_byte    = buf_r[idx_r];
  assign out_if.last_of_run = last;

  `GDT_IMPLIES(a_idx_in_run, busy_r, (len_r != '0) && (idx_r < len_r), "run index out of range")
  `GDT_NEXT(a_idx_steps, out_if.valid && out_if.ready && !out_if.last_of_run, busy_r && (idx_r == $past(idx_r) + CNT_W'(1)), "run did not advance by one")

endmodule

// ----- rtl/greek_digraph_transliterator.sv -----
`timescale 1ns / 1ps
`include "greek_digraph_transliterator_defines.svh"

// ISO-8859-7 to Latin transliterator.
// in_if: valid/ready channel; operation selects translate (byte_in) or a table
//   write of entry_text (up to three characters, low byte first) at byte_in.
// out_if: valid/ready channel of single characters; last_of_run marks the
//   final character caused by one translate transaction.
// Mu and nu are held until the next byte; mu+pi gives B/b, nu+tau gives D/d.
// The first character of a transaction is offered once the run register is
//   loaded: the table is read at the accepting edge, and the run register is
//   loaded from the read stage when the emit stage is free.
// Throughput: one character per cycle out while out_if.ready is high; a
//   transaction produces 0..6 characters, and the next one can be accepted
//   while the run register still emits. Writes and silent translates emit none.
// The table is a 256 x 24 memory with two registered read ports; a 256-bit
//   valid vector makes unwritten entries read as empty, so there is no
//   clearing pass.
// Reset: nothing held, table empty, no transaction in flight.
// Output stall: the pending run holds, a transaction with characters fills
//   the read stage behind it and in_if.ready drops until the run is released.
module greek_digraph_transliterator (
  input  logic      clk,
  input  logic      rst_n,
  gdt_in_if.sink    in_if,
  gdt_out_if.source out_if
);
  import gdt_pkg::*;

  typedef enum logic [2:0] {
    HOLD_IDLE   = 3'd0,
    HOLD_CAP_MU = 3'd1,
    HOLD_SML_MU = 3'd2,
    HOLD_CAP_NU = 3'd3,
    HOLD_SML_NU = 3'd4
  } hold_t;

  hold_t             held_r;
  hold_t             held_nxt;
  hold_t             new_hold;
  logic              s1_valid_r;
  run_ctl_t          s1_ctl_r;
  run_ctl_t          ctl_nxt;
  logic [ADDR_W-1:0] held_addr;
  logic [ENTRY_W-1:0] held_entry;
  logic [ENTRY_W-1:0] byte_entry;
  logic              take;
  logic              acc;
  logic              acc_tr;
  logic              acc_wr;
  logic [CHAR_W-1:0] ch;
  logic              is_pi;
  logic              is_tau;
  tail_t             plain_tail;

  assign ch     = in_if.byte_in;
  assign acc    = in_if.valid && in_if.ready;
  assign acc_wr = acc && (in_if.operation == OP_WRITE);
  assign acc_tr = acc && (in_if.operation == OP_TRANSLATE);

  assign in_if.ready = !s1_valid_r || take;

  always_comb begin
    priority if (ch == CODE_CAP_MU) new_hold = HOLD_CAP_MU;
    else if (ch == CODE_SML_MU)     new_hold = HOLD_SML_MU;
    else if (ch == CODE_CAP_NU)     new_hold = HOLD_CAP_NU;
    else if (ch == CODE_SML_NU)     new_hold = HOLD_SML_NU;
    else                            new_hold = HOLD_IDLE;

    unique case (held_r)
      HOLD_CAP_MU: held_addr = CODE_CAP_MU;
      HOLD_SML_MU: held_addr = CODE_SML_MU;
      HOLD_CAP_NU: held_addr = CODE_CAP_NU;
      default:     held_addr = CODE_SML_NU;
    endcase

    is_pi      = (ch == CODE_CAP_PI) || (ch == CODE_SML_PI);
    is_tau     = (ch == CODE_CAP_TAU) || (ch == CODE_SML_TAU);
    plain_tail = ((ch > RANGE_BELOW) && (ch < RANGE_ABOVE)) ? TAIL_ENTRY : TAIL_RAW;

    held_nxt          = new_hold;
    ctl_nxt.head      = HEAD_NONE;
    ctl_nxt.tail      = TAIL_NONE;
    ctl_nxt.pair_char = '0;
    ctl_nxt.raw_char  = ch;

    unique case (held_r)
      HOLD_CAP_MU, HOLD_SML_MU: begin
        if (is_pi) begin
          ctl_nxt.head      = HEAD_PAIR;
          ctl_nxt.pair_char = (held_r == HOLD_CAP_MU) ? CHAR_CAP_B : CHAR_SML_B;
          held_nxt          = HOLD_IDLE;
        end else begin
          ctl_nxt.head = HEAD_ENTRY;
          ctl_nxt.tail = (new_hold == HOLD_IDLE) ? plain_tail : TAIL_NONE;
        end
      end
      HOLD_CAP_NU, HOLD_SML_NU: begin
        if (is_tau) begin
          ctl_nxt.head      = HEAD_PAIR;
          ctl_nxt.pair_char = (held_r == HOLD_CAP_NU) ? CHAR_CAP_D : CHAR_SML_D;
          held_nxt          = HOLD_IDLE;
        end else begin
          ctl_nxt.head = HEAD_ENTRY;
          ctl_nxt.tail = (new_hold == HOLD_IDLE) ? plain_tail : TAIL_NONE;
        end
      end
      default: begin
        ctl_nxt.tail = (new_hold == HOLD_IDLE) ? plain_tail : TAIL_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r     <= HOLD_IDLE;
      s1_valid_r <= 1'b0;
    end else begin
      if (acc_tr) begin
        held_r <= held_nxt;
      end
      if (acc_tr) begin
        s1_valid_r <= 1'b1;
      end else if (take) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_tr) begin
      s1_ctl_r <= ctl_nxt;
    end
  end

  gdt_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (acc_wr),
    .wr_addr   (ch),
    .wr_data   (in_if.entry_text),
    .rd_en     (acc_tr),
    .rd_addr_a (held_addr),
    .rd_addr_b (ch),
    .rd_data_a (held_entry),
    .rd_data_b (byte_entry)
  );

  gdt_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .run_valid  (s1_valid_r),
    .run_ctl    (s1_ctl_r),
    .held_entry (held_entry),
    .byte_entry (byte_entry),
    .take       (take),
    .out_if     (out_if)
  );

  `GDT_NEXT(a_pair_clears_hold, acc_tr && (ctl_nxt.head == HEAD_PAIR), held_r == HOLD_IDLE, "digraph left a letter held")
  `GDT_NEXT(a_silent_sets_hold, acc_tr && (held_r == HOLD_IDLE) && (ctl_nxt.tail == TAIL_NONE), held_r != HOLD_IDLE, "silent translate without a held letter")
  `GDT_NEXT(a_read_stage_holds, s1_valid_r && !take, s1_valid_r && $stable(s1_ctl_r), "read stage lost a pending transaction")

endmodule
